>>> hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and sizing functions for the power-of-two slab
// allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

   // Field widths
   localparam int SIZE_W   = 20;
   localparam int ADDR_W   = 18;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Default geometry
   localparam int DEF_MIN_SLOT_LOG = 4;
   localparam int DEF_NUM_CLASSES  = 8;
   localparam int DEF_PAGE_LOG     = 12;
   localparam int DEF_MAX_PAGES    = 64;

   // Action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_PAGES     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREE_DROPPED = 3'd4;

   typedef struct packed {
      logic              action;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] address;
      logic              address_is_null;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   slot_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                capture;
      logic                push;
      logic                pop_rd;
      logic                take_page;
      logic                fill_write;
      logic                load_out;
      logic                out_from_mem;
      logic [STATUS_W-1:0] out_status;
   } psa_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_free;
      logic too_large;
      logic is_null;
      logic depth_zero;
      logic stack_full;
      logic pages_left;
      logic slots_zero;
      logic fill_last;
      logic out_free;
   } psa_flags_type;

   // Slots that one page yields in a class, zero when the slot exceeds a page
   function automatic int page_slot_count(int cls, int min_log, int page_log);
      if (min_log + cls > page_log) begin
         return 0;
      end
      return 1 << (page_log - min_log - cls);
   endfunction

   // First stack entry of a class region
   function automatic int region_base(int cls, int min_log, int page_log, int max_pages);
      int base;
      base = 0;
      for (int k = 0; k < cls; k++) begin
         base += max_pages * page_slot_count(k, min_log, page_log);
      end
      return base;
   endfunction

   function automatic int clog2_min1(int v);
      return (v > 1) ? $clog2(v) : 1;
   endfunction

endpackage

>>> hdl/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Controller: sequences one item at a time through decode, page refill,
// stack pop and result load.
// ----------------------------------------------------------------------------
module psa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  psa_pkg::psa_flags_type flags,
   output psa_pkg::psa_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_FILL = 4'b0100,
      S_POP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!flags.is_free) begin
               if (flags.too_large) begin
                  if (flags.out_free) begin
                     cmd.load_out   = 1'b1;
                     cmd.out_status = psa_pkg::ST_TOO_LARGE;
                     state_in       = S_IDLE;
                  end
               end else if (!flags.depth_zero) begin
                  cmd.pop_rd = 1'b1;
                  state_in   = S_POP;
               end else if (!flags.pages_left) begin
                  if (flags.out_free) begin
                     cmd.load_out   = 1'b1;
                     cmd.out_status = psa_pkg::ST_NO_PAGES;
                     state_in       = S_IDLE;
                  end
               end else if (flags.slots_zero) begin
                  // page is used up but gives no slot
                  if (flags.out_free) begin
                     cmd.take_page  = 1'b1;
                     cmd.load_out   = 1'b1;
                     cmd.out_status = psa_pkg::ST_NO_PAGES;
                     state_in       = S_IDLE;
                  end
               end else begin
                  cmd.take_page = 1'b1;
                  state_in      = S_FILL;
               end
            end else begin
               if (flags.too_large || flags.is_null) begin
                  if (flags.out_free) begin
                     cmd.load_out   = 1'b1;
                     cmd.out_status = psa_pkg::ST_FREE_IGNORED;
                     state_in       = S_IDLE;
                  end
               end else if (flags.stack_full) begin
                  if (flags.out_free) begin
                     cmd.load_out   = 1'b1;
                     cmd.out_status = psa_pkg::ST_FREE_DROPPED;
                     state_in       = S_IDLE;
                  end
               end else if (flags.out_free) begin
                  cmd.push       = 1'b1;
                  cmd.load_out   = 1'b1;
                  cmd.out_status = psa_pkg::ST_DONE;
                  state_in       = S_IDLE;
               end
            end
         end
         S_FILL: begin
            // one slot pushed per cycle, then retry the allocate
            cmd.fill_write = 1'b1;
            if (flags.fill_last) begin
               state_in = S_EVAL;
            end
         end
         S_POP: begin
            if (flags.out_free) begin
               cmd.load_out     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_status   = psa_pkg::ST_DONE;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/psa_dp.sv
// ----------------------------------------------------------------------------
// psa_dp
// Datapath: request register, size class decode, per-class stack depths,
// page counter, free slot memory and result register.
// ----------------------------------------------------------------------------
module psa_dp #(
   parameter int MIN_SLOT_LOG = psa_pkg::DEF_MIN_SLOT_LOG,
   parameter int NUM_CLASSES  = psa_pkg::DEF_NUM_CLASSES,
   parameter int PAGE_LOG     = psa_pkg::DEF_PAGE_LOG,
   parameter int MAX_PAGES    = psa_pkg::DEF_MAX_PAGES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psa_pkg::req_type              req_payload,
   output psa_pkg::rsp_type              rsp_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          csr_wr_en,
   input  logic [psa_pkg::LIMIT_W-1:0]   csr_wr_data,
   input  psa_pkg::psa_cmd_type          cmd,
   output psa_pkg::psa_flags_type        flags
);

   localparam int SLOTS_MAX = 1 << (PAGE_LOG - MIN_SLOT_LOG);
   localparam int CAP_MAX   = MAX_PAGES * SLOTS_MAX;
   localparam int DEPTH_W   = $clog2(CAP_MAX + 1);
   localparam int FILL_W    = psa_pkg::clog2_min1(SLOTS_MAX);
   localparam int MEM_DEPTH = psa_pkg::region_base(NUM_CLASSES, MIN_SLOT_LOG, PAGE_LOG,
                                                   MAX_PAGES);
   localparam int MEM_AW    = psa_pkg::clog2_min1(MEM_DEPTH);
   localparam int PG_W      = $clog2(MAX_PAGES + 1);
   localparam int CLS_W     = $clog2(NUM_CLASSES + 1);
   localparam int IDX_W     = psa_pkg::clog2_min1(NUM_CLASSES);
   localparam int CMP_W     = (PG_W > psa_pkg::LIMIT_W) ? PG_W : psa_pkg::LIMIT_W;
   localparam int ADDR_W    = psa_pkg::ADDR_W;

   psa_pkg::req_type             req_ff;
   logic [psa_pkg::LIMIT_W-1:0]  limit_ff;
   logic [PG_W-1:0]              pages_ff;
   logic [PG_W-1:0]              fill_page_ff;
   logic [FILL_W-1:0]            fill_idx_ff;
   logic [DEPTH_W-1:0]           depth_ff [NUM_CLASSES];
   logic [ADDR_W-1:0]            rd_data_ff;
   logic                         rsp_valid_ff;
   psa_pkg::rsp_type             rsp_ff;
   logic [ADDR_W-1:0]            mem [MEM_DEPTH];

   logic [MEM_AW-1:0]  base_tbl [NUM_CLASSES];
   logic [DEPTH_W-1:0] cap_tbl  [NUM_CLASSES];
   logic [FILL_W-1:0]  last_tbl [NUM_CLASSES];
   logic               zero_tbl [NUM_CLASSES];

   logic [NUM_CLASSES-1:0] over;
   logic [CLS_W-1:0]       cls_cnt;
   logic [IDX_W-1:0]       cls;
   logic [DEPTH_W-1:0]     depth_cur;
   logic [MEM_AW-1:0]      top_addr;
   logic [MEM_AW-1:0]      pop_addr;
   logic [ADDR_W-1:0]      fill_off;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_wdata;

   // Per-class constant tables
   for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_tbl
      localparam int S = psa_pkg::page_slot_count(k, MIN_SLOT_LOG, PAGE_LOG);
      assign base_tbl[k] = MEM_AW'(psa_pkg::region_base(k, MIN_SLOT_LOG, PAGE_LOG,
                                                        MAX_PAGES));
      assign cap_tbl[k]  = DEPTH_W'(MAX_PAGES * S);
      assign last_tbl[k] = FILL_W'((S > 0) ? S - 1 : 0);
      assign zero_tbl[k] = (S == 0);
   end

   // Size class: number of class limits the size exceeds
   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cls
      assign over[c] = req_ff.request_size > psa_pkg::SIZE_W'(1 << (MIN_SLOT_LOG + c));
   end
   assign cls_cnt = CLS_W'($countones(over));
   assign cls     = cls_cnt[IDX_W-1:0];

   assign depth_cur = depth_ff[cls];
   assign top_addr  = base_tbl[cls] + MEM_AW'(depth_cur);
   assign pop_addr  = top_addr - MEM_AW'(1);
   assign fill_off  = (ADDR_W'(fill_page_ff) << PAGE_LOG)
                    + (ADDR_W'(fill_idx_ff) << (MIN_SLOT_LOG + cls));

   // Status to the controller
   always_comb begin
      flags.is_free    = (req_ff.action == psa_pkg::ACT_FREE);
      flags.too_large  = (cls_cnt == CLS_W'(NUM_CLASSES));
      flags.is_null    = req_ff.address_is_null;
      flags.depth_zero = (depth_cur == '0);
      flags.stack_full = (depth_cur >= cap_tbl[cls]);
      flags.pages_left = (CMP_W'(pages_ff) < CMP_W'(limit_ff))
                      && (pages_ff < PG_W'(MAX_PAGES));
      flags.slots_zero = zero_tbl[cls];
      flags.fill_last  = (fill_idx_ff == last_tbl[cls]);
      flags.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Request and configuration registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= psa_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Page counter and refill sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= '0;
      end else if (cmd.take_page) begin
         pages_ff <= pages_ff + PG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_page) begin
         fill_page_ff <= pages_ff;
         fill_idx_ff  <= '0;
      end else if (cmd.fill_write) begin
         fill_idx_ff  <= fill_idx_ff + FILL_W'(1);
      end
   end

   // Stack depths
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            depth_ff[k] <= '0;
         end
      end else if (cmd.push || cmd.fill_write) begin
         depth_ff[cls] <= depth_cur + DEPTH_W'(1);
      end else if (cmd.pop_rd) begin
         depth_ff[cls] <= depth_cur - DEPTH_W'(1);
      end
   end

   // Free slot memory, one write and one registered read
   assign mem_we    = cmd.push || cmd.fill_write;
   assign mem_wdata = cmd.fill_write ? fill_off : req_ff.address;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[top_addr] <= mem_wdata;
      end
      if (cmd.pop_rd) begin
         rd_data_ff <= mem[pop_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.slot_address <= cmd.out_from_mem ? rd_data_ff : '0;
         rsp_ff.status       <= cmd.out_status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/power_of_two_slab_allocator.sv
// ----------------------------------------------------------------------------
// power_of_two_slab_allocator
// Slab allocator with power-of-two size classes over a paged arena.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A free, a rejected request or an error
// result is settled in the evaluate state and loaded into the output
// register; an allocate that pops its class stack passes first through a
// pop state for the registered read of the free slot memory. An allocate
// that finds its stack empty first refills it from a fresh page: it claims
// the page, then writes one slot per cycle into that memory, for
// 2^(PAGE_LOG - MIN_SLOT_LOG - class) slots in all (256 for the smallest
// class at default settings). The slot memory needs no clearing after reset;
// an item can be accepted in the first cycle out of reset. The result waits
// in an output register, so a stalled result does not hold back the next
// item's accept.
module power_of_two_slab_allocator #(
   parameter int MIN_SLOT_LOG = psa_pkg::DEF_MIN_SLOT_LOG,
   parameter int NUM_CLASSES  = psa_pkg::DEF_NUM_CLASSES,
   parameter int PAGE_LOG     = psa_pkg::DEF_PAGE_LOG,
   parameter int MAX_PAGES    = psa_pkg::DEF_MAX_PAGES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  psa_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output psa_pkg::rsp_type            rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [psa_pkg::LIMIT_W-1:0] csr_wr_data
);

   psa_pkg::psa_cmd_type   cmd;
   psa_pkg::psa_flags_type flags;

   // Controller
   psa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Datapath
   psa_dp #(
      .MIN_SLOT_LOG (MIN_SLOT_LOG),
      .NUM_CLASSES  (NUM_CLASSES),
      .PAGE_LOG     (PAGE_LOG),
      .MAX_PAGES    (MAX_PAGES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .flags       (flags)
   );

endmodule

>>> hdl/psa_checker.sv
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks for the slab allocator, bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input psa_pkg::rsp_type            rsp_payload
);

   // No result is pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // One item in flight: an accept is followed by a stall
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // Status code in range
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= psa_pkg::ST_FREE_DROPPED)
      else $error("illegal status");

   // Only a successful item carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != psa_pkg::ST_DONE |-> rsp_payload.slot_address == '0)
      else $error("address on failed item");

endmodule

bind power_of_two_slab_allocator psa_checker u_psa_checker (.*);

>>> bench/power_of_two_slab_allocator_tb.sv
// ----------------------------------------------------------------------------
// power_of_two_slab_allocator_tb
// Self-checking bench for the slab allocator. A directed table covers the
// class boundaries, oversize and null requests, and pop order after a page
// split. It is followed by random alloc/free traffic under several page
// limits and a free burst that overflows the largest class. Every result is
// checked in order against a fixed row or a behavioral allocator in the bench.
// ----------------------------------------------------------------------------
module power_of_two_slab_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MIN_LOG     = psa_pkg::DEF_MIN_SLOT_LOG;
   localparam int CLASSES     = psa_pkg::DEF_NUM_CLASSES;
   localparam int PG_LOG      = psa_pkg::DEF_PAGE_LOG;
   localparam int PAGES       = psa_pkg::DEF_MAX_PAGES;
   localparam int SIZE_W      = psa_pkg::SIZE_W;
   localparam int ADDR_W      = psa_pkg::ADDR_W;
   localparam int STATUS_W    = psa_pkg::STATUS_W;
   localparam int LIMIT_W     = psa_pkg::LIMIT_W;
   localparam int STORE_DEPTH = 2 * PAGES * (1 << (PG_LOG - MIN_LOG));
   localparam int STALL_LIMIT = 3000;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   psa_pkg::req_type   req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   psa_pkg::rsp_type   rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   // One row of the directed table; want is only used when fixed is set
   typedef struct {
      psa_pkg::req_type item;
      bit               fixed;
      psa_pkg::rsp_type want;
   } vector_row_type;

   // Allocator image: per-class stack regions, fill levels, pages used
   logic [ADDR_W-1:0]  slot_store [STORE_DEPTH];
   int                 class_fill [CLASSES];
   int                 pages_taken;
   logic [LIMIT_W-1:0] page_cap;

   psa_pkg::rsp_type   pending_results [$];
   logic [ADDR_W-1:0]  held_addr [$];
   int                 held_class [$];
   vector_row_type     directed_rows [$];
   int                 error_count;
   int                 quiet_cycles;
   bit                 quiet;

   power_of_two_slab_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Slots carved from one page; zero once a slot outgrows the page
   function automatic int per_page(int c);
      if (MIN_LOG + c > PG_LOG) begin
         return 0;
      end
      return 1 << (PG_LOG - MIN_LOG - c);
   endfunction

   function automatic int store_base(int c);
      int b;
      b = 0;
      for (int k = 0; k < c; k++) begin
         b += PAGES * per_page(k);
      end
      return b;
   endfunction

   // CLASSES means too large
   function automatic int class_of(logic [SIZE_W-1:0] size);
      int c;
      if (size <= (1 << MIN_LOG)) begin
         return 0;
      end
      if (size > (1 << (MIN_LOG + CLASSES - 1))) begin
         return CLASSES;
      end
      c = 1;
      while ((1 << (MIN_LOG + c)) < size) begin
         c++;
      end
      return c;
   endfunction

   // Applies one request to the allocator image and returns its result
   function automatic psa_pkg::rsp_type allocator_predict(psa_pkg::req_type r);
      psa_pkg::rsp_type o;
      int               c;
      int               avail;
      int               b;
      o = '0;
      o.status = psa_pkg::ST_DONE;
      c = class_of(r.request_size);
      if (r.action == psa_pkg::ACT_ALLOC) begin
         if (c >= CLASSES) begin
            o.status = psa_pkg::ST_TOO_LARGE;
         end else begin
            b = store_base(c);
            avail = (page_cap < PAGES) ? int'(page_cap) : PAGES;
            // Empty stack: split the next page, pushed low to high
            if (class_fill[c] == 0 && pages_taken < avail) begin
               for (int i = 0; i < per_page(c); i++) begin
                  slot_store[b + class_fill[c]] =
                     ADDR_W'((pages_taken << PG_LOG) + (i << (MIN_LOG + c)));
                  class_fill[c]++;
               end
               pages_taken++;
            end
            if (class_fill[c] == 0) begin
               o.status = psa_pkg::ST_NO_PAGES;
            end else begin
               class_fill[c]--;
               o.slot_address = slot_store[b + class_fill[c]];
            end
         end
      end else begin
         if (c >= CLASSES || r.address_is_null) begin
            o.status = psa_pkg::ST_FREE_IGNORED;
         end else if (class_fill[c] >= PAGES * per_page(c)) begin
            o.status = psa_pkg::ST_FREE_DROPPED;
         end else begin
            slot_store[store_base(c) + class_fill[c]] = r.address;
            class_fill[c]++;
         end
      end
      return o;
   endfunction

   function automatic logic [SIZE_W-1:0] size_in_class(int c);
      if (c == 0) begin
         return SIZE_W'($urandom_range(1 << MIN_LOG));
      end
      return SIZE_W'($urandom_range(1 << (MIN_LOG + c), (1 << (MIN_LOG + c - 1)) + 1));
   endfunction

   function automatic vector_row_type make_row(logic act, int size, int addr, bit nul,
                                               bit fixed, int slot,
                                               logic [STATUS_W-1:0] st);
      vector_row_type v;
      v.item.action          = act;
      v.item.request_size    = SIZE_W'(size);
      v.item.address         = ADDR_W'(addr);
      v.item.address_is_null = nul;
      v.fixed                = fixed;
      v.want.slot_address    = ADDR_W'(slot);
      v.want.status          = st;
      return v;
   endfunction

   // Appends one row to the directed table
   task automatic add_row(input logic act, input int size, input int addr, input bit nul,
                          input bit fixed, input int slot,
                          input logic [STATUS_W-1:0] st);
      directed_rows = {directed_rows, make_row(act, size, addr, nul, fixed, slot, st)};
   endtask

   // Random request: mostly frees of held slots and allocs, some noise
   task automatic make_request(output psa_pkg::req_type r);
      int pick;
      int k;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 40 && held_addr.size() != 0) begin
         k = $urandom_range(held_addr.size() - 1);
         r.action       = psa_pkg::ACT_FREE;
         r.request_size = size_in_class(held_class[k]);
         r.address      = held_addr[k];
         held_addr.delete(k);
         held_class.delete(k);
      end else if (pick < 78) begin
         r.action       = psa_pkg::ACT_ALLOC;
         r.request_size = size_in_class($urandom_range(CLASSES - 1));
      end else if (pick < 88) begin
         r.action          = 1'($urandom_range(1));
         r.request_size    = SIZE_W'($urandom);
         r.address         = ADDR_W'($urandom);
         r.address_is_null = 1'($urandom_range(1));
      end else if (pick < 93) begin
         r.action          = psa_pkg::ACT_FREE;
         r.request_size    = size_in_class($urandom_range(CLASSES - 1));
         r.address         = ADDR_W'($urandom);
         r.address_is_null = 1'b1;
      end else if (pick < 97) begin
         r.action       = psa_pkg::ACT_ALLOC;
         r.request_size = SIZE_W'($urandom_range(20'hFFFFF, (1 << (MIN_LOG + CLASSES - 1)) + 1));
      end else begin
         // stray pointer into a valid class
         r.action       = psa_pkg::ACT_FREE;
         r.request_size = size_in_class($urandom_range(CLASSES - 1));
         r.address      = ADDR_W'($urandom);
      end
   endtask

   // Drive one item, hold it until accepted, then record its expected result
   task automatic send_item(input psa_pkg::req_type item, input bit fixed,
                            input psa_pkg::rsp_type want);
      psa_pkg::rsp_type p;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      p = allocator_predict(item);
      if (item.action == psa_pkg::ACT_ALLOC && p.status == psa_pkg::ST_DONE) begin
         held_addr  = {held_addr, p.slot_address};
         held_class = {held_class, class_of(item.request_size)};
      end
      pending_results = {pending_results, (fixed ? want : p)};
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_page_limit(input logic [LIMIT_W-1:0] v);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      page_cap     = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int count);
      psa_pkg::req_type r;
      repeat (count) begin
         make_request(r);
         send_item(r, 1'b0, '0);
      end
   endtask

   // Result sink stalls at random unless in a quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 15);
   end

   // Result checker
   always @(posedge clock) begin
      psa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result slot=%0d status=%0d", $time,
                     rsp_payload.slot_address, rsp_payload.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.slot_address !== want.slot_address) begin
               $display("%0t: slot_address expected %0d got %0d", $time,
                        want.slot_address, rsp_payload.slot_address);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time,
                        want.status, rsp_payload.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("power_of_two_slab_allocator_tb: errors");
         $finish;
      end
   end

   initial begin
      psa_pkg::req_type r;
      error_count  = 0;
      quiet        = 1'b0;
      pages_taken  = 0;
      page_cap     = psa_pkg::LIMIT_RESET;
      for (int c = 0; c < CLASSES; c++) begin
         class_fill[c] = 0;
      end

      // Directed rows, run from reset with all pages available
      add_row(psa_pkg::ACT_ALLOC, 0, 0, 0, 1, 4080, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 16, 0, 0, 1, 4064, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 17, 0, 0, 1, 8160, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 2048, 0, 0, 1, 10240, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 2049, 0, 0, 1, 0, psa_pkg::ST_TOO_LARGE);
      add_row(psa_pkg::ACT_ALLOC, 20'hFFFFF, 18'h3FFFF, 1, 1, 0, psa_pkg::ST_TOO_LARGE);
      add_row(psa_pkg::ACT_FREE, 16, 18'h3FFFF, 1, 1, 0, psa_pkg::ST_FREE_IGNORED);
      add_row(psa_pkg::ACT_FREE, 20'hFFFFF, 5, 0, 1, 0, psa_pkg::ST_FREE_IGNORED);
      add_row(psa_pkg::ACT_FREE, 20'hFFFFF, 0, 1, 1, 0, psa_pkg::ST_FREE_IGNORED);
      add_row(psa_pkg::ACT_FREE, 2048, 18'h3FFFF, 0, 1, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 1025, 0, 0, 1, 18'h3FFFF, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 2000, 0, 0, 1, 8192, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 1500, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_FREE, 1, 0, 0, 1, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 0, 0, 0, 1, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 33, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 64, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 65, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 200, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 256, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 300, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 513, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_ALLOC, 1024, 0, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_FREE, 200, 18'h2AAAA, 0, 0, 0, psa_pkg::ST_DONE);
      add_row(psa_pkg::ACT_FREE, 600, 18'h15555, 0, 0, 0, psa_pkg::ST_DONE);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      end

      // No pages at all: only stacked slots can be handed out
      set_page_limit(7'd0);
      run_random(40);

      // Widest limit, above the arena size, with both sides running flat out
      set_page_limit(7'd127);
      quiet = 1'b1;
      run_random(120);
      quiet = 1'b0;

      set_page_limit(7'd1);
      run_random(40);

      set_page_limit(7'd30);
      run_random(40);

      // Free burst into the largest class until its region overflows
      repeat (140) begin
         r                 = '0;
         r.action          = psa_pkg::ACT_FREE;
         r.request_size    = size_in_class(CLASSES - 1);
         r.address         = ADDR_W'($urandom);
         send_item(r, 1'b0, '0);
      end

      set_page_limit(7'd64);
      run_random(50);

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("power_of_two_slab_allocator_tb: clean");
      end else begin
         $display("power_of_two_slab_allocator_tb: errors");
      end
      $finish;
   end

endmodule
